@@ design/rrq_pkg.sv @@
// ----------------------------------------------------------------------------
// rrq_pkg: shared types and codes for the round-robin ready queue
// Beat structs, request and status codes, controller/datapath command links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 8;

    localparam int KIND_W   = 2;
    localparam int TID_W    = 8;
    localparam int CHOSEN_W = 8;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 5;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADMIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TID_W-1:0]  thread_id;
    } t_req;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen_id;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live_count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic exec;       // decode request, do clear/admit work, start next/remove
        logic nxt_wr;     // next: rotate head id to tail
        logic srch_step;  // remove: one search/compact step
        logic srch_fin;   // remove: close out
        logic emit;       // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              srch_done;
        logic              out_busy;
    } t_sts;

endpackage

@@ design/rrq_dpath.sv @@
// ----------------------------------------------------------------------------
// rrq_dpath: ready queue datapath
// Slot memory, head/count registers, search-and-compact walk, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrq_dpath import rrq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // slot index: a + b modulo depth, with a < depth and b <= depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return AW'(s);
    endfunction

    logic [ID_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] r_rd_data;

    logic [KIND_W-1:0]   r_kind;
    logic [ID_WIDTH-1:0] r_tid;
    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_off;
    logic [CW-1:0]       r_pend_off;
    logic                r_pend;
    logic                r_found;
    logic [ID_WIDTH-1:0] r_chosen;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    t_rsp                r_rsp;

    logic                we;
    logic                ren;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [ID_WIDTH-1:0] wdata;
    logic                full;
    logic                empty;
    logic                more;
    logic                hit;

    assign full  = (r_count == CW'(QUEUE_DEPTH));
    assign empty = (r_count == '0);
    assign more  = (r_off != r_count);
    assign hit   = (r_rd_data == r_tid);

    // memory port steering
    always_comb begin
        we    = 1'b0;
        ren   = 1'b0;
        waddr = wrap_add(r_head, r_count);
        raddr = r_head;
        wdata = r_tid;
        if (i_cmd.exec && r_kind == KIND_ADMIT && !full) begin
            we = 1'b1;
        end
        if (i_cmd.exec && r_kind == KIND_NEXT && !empty) begin
            ren = 1'b1;
        end
        if (i_cmd.nxt_wr) begin
            we    = 1'b1;
            wdata = r_rd_data;
        end
        if (i_cmd.srch_step) begin
            if (more) begin
                ren   = 1'b1;
                raddr = wrap_add(r_head, r_off);
            end
            // past the match: shift each later id down one slot
            if (r_pend && r_found) begin
                we    = 1'b1;
                waddr = wrap_add(r_head, r_pend_off - CW'(1));
                wdata = r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (ren) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                case (r_kind)
                    KIND_CLEAR: begin
                        r_head  <= '0;
                        r_count <= '0;
                    end
                    KIND_ADMIT: begin
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    KIND_REMOVE: begin
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.nxt_wr) begin
                r_head <= wrap_add(r_head, CW'(1));
            end
            if (i_cmd.srch_step) begin
                r_pend <= more;
                if (r_pend && !r_found && hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.srch_fin && r_found) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req.kind;
            r_tid  <= ID_WIDTH'(i_req.thread_id);
        end
        if (i_cmd.exec) begin
            r_chosen <= '0;
            r_off    <= '0;
            case (r_kind)
                KIND_ADMIT:  r_status <= full ? ST_FULL : ST_OK;
                KIND_REMOVE: r_status <= ST_NOT_FOUND;
                KIND_NEXT:   r_status <= empty ? ST_EMPTY : ST_OK;
                default:     r_status <= ST_OK;
            endcase
        end
        if (i_cmd.nxt_wr) begin
            r_chosen <= r_rd_data;
        end
        if (i_cmd.srch_step && more) begin
            r_off      <= r_off + CW'(1);
            r_pend_off <= r_off;
        end
        if (i_cmd.srch_fin && r_found) begin
            r_status <= ST_OK;
        end
        if (i_cmd.emit) begin
            r_rsp.chosen_id  <= CHOSEN_W'(r_chosen);
            r_rsp.status     <= r_status;
            r_rsp.live_count <= LIVE_W'(r_count);
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.empty     = empty;
    assign o_sts.srch_done = !more && !r_pend;
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ design/rrq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrq_ctrl: ready queue controller
// Sequences one request at a time and issues datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrq_ctrl import rrq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NXT,
        S_SRCH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.kind == KIND_NEXT && !i_sts.empty) begin
                    n_state = S_NXT;
                end else if (i_sts.kind == KIND_REMOVE) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NXT: begin
                o_cmd.nxt_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_done) begin
                    o_cmd.srch_fin = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

endmodule

@@ design/round_robin_ready_queue_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_ready_queue_unit: round-robin scheduler ready queue
// Sequencing: clear/admit pass IDLE, EXEC, DONE; next adds NXT on a non-empty
// queue; remove stays in SRCH while it walks every queued id. Remove walks the
// slot memory one entry per cycle through its single read port.
// Throughput: one request in flight; a new beat is taken the cycle after the
// result is loaded into the output register, even while that result waits.
// Reset: synchronous, active low; queue empty, head at slot 0, no output beat.
// Slot contents are not cleared; only live slots are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_ready_queue_unit import rrq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_data,
    // result channel
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_data
);

    // Controller and datapath talk only through these two structs.
    t_cmd cmd;
    t_sts sts;

    // Controller: IDLE -> EXEC, then NXT (next on non-empty queue), SRCH
    // (remove walk) or straight to DONE, which loads the output register
    // once the previous result has been taken.
    rrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: circular slot memory with registered read, head and count
    // registers, the remove walk (search, then shift each later id down one
    // slot in the same pass), and the output register that decouples the
    // result side from the request side.
    rrq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_rsp       (o_data)
    );

endmodule

@@ design/rrq_chk.sv @@
// ----------------------------------------------------------------------------
// rrq_chk: port-level checks for the ready queue
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrq_chk import rrq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_data,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_data
);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input beat changed while stalled");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // one request at a time: a taken beat closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while one is in progress");

    // empty report carries no id and a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_EMPTY |->
            o_data.live_count == '0 && o_data.chosen_id == '0)
        else $error("empty status with nonzero count or id");

    // full report only at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_FULL |->
            o_data.live_count == LIVE_W'(QUEUE_DEPTH) && o_data.chosen_id == '0)
        else $error("full status below capacity");

endmodule

bind round_robin_ready_queue_unit rrq_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rrq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
